// ===== rtl/ffha_pkg.sv =====
// Shared status and action codes for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;
  localparam logic       ACT_ALLOC  = 1'b0;
  localparam logic       ACT_FREE   = 1'b1;
endpackage

// ===== rtl/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator with coalescing.
//
// Usage: raise start with in_action, in_request_bytes and in_free_offset while
// busy is low; the item is taken at that edge and busy rises. A small
// sequencer walks the address-ordered block table one entry at a time
// (read, then evaluate the registered data). On a split it moves entries up
// one place, and on a merge it moves them down, each with a read and a write.
// A zero request, a request above the free total or a misaligned free is
// answered without a scan of the table. Busy falls in the cycle that shows
// the result, so the next item may be taken at the edge that ends it; the
// block takes no new item before it is through with the last one.
// The result stays on out_status, out_payload_offset and out_avail_bytes for
// one cycle with out_valid high; the receiver cannot stall and takes it then.
// Reset (synchronous, rst_n low) leaves one free block spanning the heap and
// a free total of HEAP_BYTES; after reset the S_INIT state writes that block,
// with busy high.
// Each table entry (size and busy flag) is one word of a memory with one
// write port and one registered read port.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 16,
  parameter int ALIGN_BYTES  = 8,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [12:0] in_request_bytes,
  input  logic [15:0] in_free_offset,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [11:0] out_payload_offset,
  output logic [12:0] out_avail_bytes
);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = $clog2(HEAP_BYTES + HEADER_BYTES + 1) + 1;
  localparam int EW = SW + 1;
  localparam logic [SW-1:0] HDR     = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] AM      = SW'(ALIGN_BYTES - 1);
  localparam logic [15:0]   AM_OFF  = 16'(ALIGN_BYTES - 1);
  localparam logic [12:0]   HDR_T   = 13'(HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  localparam logic [3:0] S_INIT = 4'd0;  // write the first block
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;  // issue read of entry idx
  localparam logic [3:0] S_EV   = 4'd3;  // evaluate read data
  localparam logic [3:0] S_URD  = 4'd4;  // split: read j-1
  localparam logic [3:0] S_UWR  = 4'd5;  // split: write j
  localparam logic [3:0] S_SPA  = 4'd6;  // split: write granted part
  localparam logic [3:0] S_SPB  = 4'd7;  // split: write remainder
  localparam logic [3:0] S_NRD  = 4'd8;  // free: read next entry
  localparam logic [3:0] S_NEV  = 4'd9;  // free: decide merges
  localparam logic [3:0] S_WLO  = 4'd10; // free: write merged block
  localparam logic [3:0] S_DRD  = 4'd11; // merge: read j+k
  localparam logic [3:0] S_DWR  = 4'd12; // merge: write j
  localparam logic [3:0] S_DONE = 4'd13;

  // block table memory: {busy, size}
  logic [EW-1:0] mem [MAX_BLOCKS];
  logic [EW-1:0] rd_r;
  logic          we;
  logic [IW-1:0] wa, ra;
  logic [EW-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  logic [3:0]    st_r;
  logic          act_r;
  logic [SW-1:0] size_r;    // aligned request
  logic [15:0]   tgt_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;     // scan index, then the entry hit
  logic [CW-1:0] j_r;
  logic [CW-1:0] lo_r;      // lowest entry of a merge
  logic [1:0]    k_r;       // entries removed by a merge
  logic [15:0]   off_r;
  logic [SW-1:0] s_r;       // remainder of a split, or size of a freed block
  logic [SW-1:0] psz_r;     // size of the entry before idx
  logic          pbusy_r;
  logic          pfree_r;
  logic [12:0]   tot_r;
  logic [1:0]    stat_r;
  logic          valid_r;

  // decode the registered table word
  logic [SW-1:0] dsz;
  logic          dbusy;
  logic          alloc_fit;
  logic [SW-1:0] rem;
  logic          do_split;
  logic          last_ent;
  logic          nfree;
  logic [SW-1:0] rnd;

  assign dsz       = rd_r[SW-1:0];
  assign dbusy     = rd_r[SW];
  assign alloc_fit = !dbusy && (dsz >= size_r + HDR);
  assign rem       = dsz - HDR - size_r;
  assign do_split  = (rem >= HDR) && (cnt_r < CNT_MAX);
  assign last_ent  = (idx_r + 1'b1 >= cnt_r);
  assign nfree     = (idx_r + 1'b1 < cnt_r) && !dbusy;
  assign rnd       = (SW'(in_request_bytes) + AM) & ~AM;

  // drive the memory ports from the sequencer state
  always_comb begin
    we = 1'b0;
    wa = idx_r[IW-1:0];
    wd = rd_r;
    ra = idx_r[IW-1:0];
    unique case (st_r)
      S_INIT: begin
        we = 1'b1; wa = '0; wd = {1'b0, SW'(HEAP_BYTES + HEADER_BYTES)};
      end
      S_EV: begin
        if (act_r == ffha_pkg::ACT_ALLOC && alloc_fit && !do_split) begin
          we = 1'b1; wd = {1'b1, dsz};
        end
      end
      S_URD:   ra = IW'(j_r - 1'b1);
      S_UWR:   begin we = 1'b1; wa = j_r[IW-1:0]; end
      S_SPA:   begin we = 1'b1; wd = {1'b1, SW'(HDR + size_r)}; end
      S_SPB:   begin we = 1'b1; wa = IW'(idx_r + 1'b1); wd = {1'b0, s_r}; end
      S_NRD:   ra = IW'(idx_r + 1'b1);
      S_WLO:   begin we = 1'b1; wa = lo_r[IW-1:0]; wd = {1'b0, s_r}; end
      S_DRD:   ra = IW'(j_r + CW'(k_r));
      S_DWR:   begin we = 1'b1; wa = j_r[IW-1:0]; end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; cnt_r <= CW'(1); tot_r <= 13'(HEAP_BYTES);
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (st_r)
        S_INIT: st_r <= S_IDLE;
        S_IDLE: if (start) begin
          act_r <= in_action; size_r <= rnd; tgt_r <= in_free_offset;
          idx_r <= '0; off_r <= '0; pbusy_r <= 1'b1; stat_r <= ffha_pkg::ST_OK;
          if (in_action == ffha_pkg::ACT_ALLOC &&
              (rnd == '0 || SW'(tot_r) < rnd)) begin
            stat_r <= ffha_pkg::ST_REFUSED; st_r <= S_DONE;
          end else if (in_action == ffha_pkg::ACT_FREE &&
                       (in_free_offset & AM_OFF) != '0) begin
            stat_r <= ffha_pkg::ST_BADFREE; st_r <= S_DONE;
          end else st_r <= S_RD;
        end
        S_RD: st_r <= S_EV;
        S_EV: begin
          if (act_r == ffha_pkg::ACT_ALLOC && alloc_fit) begin
            if (do_split) begin
              s_r <= rem; tot_r <= tot_r - 13'(size_r + HDR); j_r <= cnt_r;
              st_r <= (cnt_r > idx_r + 1'b1) ? S_URD : S_SPA;
            end else begin
              tot_r <= tot_r - 13'(dsz - HDR); st_r <= S_DONE;
            end
          end else if (act_r == ffha_pkg::ACT_FREE && off_r == tgt_r) begin
            if (dbusy) begin
              s_r <= dsz; pfree_r <= (idx_r != '0) && !pbusy_r; st_r <= S_NRD;
            end else begin
              stat_r <= ffha_pkg::ST_BADFREE; st_r <= S_DONE;
            end
          end else if (last_ent || (act_r == ffha_pkg::ACT_FREE && off_r > tgt_r)) begin
            stat_r <= (act_r == ffha_pkg::ACT_ALLOC) ? ffha_pkg::ST_REFUSED
                                                       : ffha_pkg::ST_BADFREE;
            st_r <= S_DONE;
          end else begin
            off_r <= off_r + 16'(dsz); psz_r <= dsz; pbusy_r <= dbusy;
            idx_r <= idx_r + 1'b1; st_r <= S_RD;
          end
        end
        // split: move entries up one place, top down
        S_URD: st_r <= S_UWR;
        S_UWR: begin
          j_r <= j_r - 1'b1;
          st_r <= (j_r - 1'b1 > idx_r + 1'b1) ? S_URD : S_SPA;
        end
        S_SPA: st_r <= S_SPB;
        S_SPB: begin
          cnt_r <= cnt_r + 1'b1; st_r <= S_DONE;
        end
        // free: join with a free next and a free previous neighbor
        S_NRD: st_r <= S_NEV;
        S_NEV: begin
          s_r <= (pfree_r ? psz_r : '0) + s_r + (nfree ? dsz : '0);
          k_r <= {1'b0, pfree_r} + {1'b0, nfree};
          lo_r <= pfree_r ? idx_r - 1'b1 : idx_r;
          tot_r <= tot_r + 13'(s_r - HDR) + (pfree_r ? HDR_T : '0) +
                   (nfree ? HDR_T : '0);
          st_r <= S_WLO;
        end
        S_WLO: begin
          j_r <= lo_r + 1'b1;
          if (k_r == 2'd0 || lo_r + 1'b1 + CW'(k_r) >= cnt_r) begin
            cnt_r <= cnt_r - CW'(k_r); st_r <= S_DONE;
          end else st_r <= S_DRD;
        end
        // merge: move entries down k places, bottom up
        S_DRD: st_r <= S_DWR;
        S_DWR: begin
          j_r <= j_r + 1'b1;
          if (j_r + 1'b1 + CW'(k_r) < cnt_r) st_r <= S_DRD;
          else begin
            cnt_r <= cnt_r - CW'(k_r); st_r <= S_DONE;
          end
        end
        S_DONE: begin
          valid_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_status = stat_r;
  assign out_payload_offset = (act_r == ffha_pkg::ACT_ALLOC && stat_r == ffha_pkg::ST_OK)
                              ? off_r[11:0] : '0;
  assign out_avail_bytes = tot_r;
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the first-fit heap allocator.
`timescale 1ns / 1ps
module tb_top;

  localparam int HEAP   = 4096;
  localparam int HDR    = 16;
  localparam int ALIGN  = 8;
  localparam int NBLK   = 64;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [12:0] in_request_bytes;
  logic [15:0] in_free_offset;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [11:0] out_payload_offset;
  logic [12:0] out_avail_bytes;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] offset;
    logic [12:0] avail;
  } heap_result_t;

  heap_result_t expected_q[$];
  int unsigned  blk_size[NBLK];
  bit           blk_busy[NBLK];
  int unsigned  blk_count;
  int unsigned  free_total;
  int unsigned  live_offsets[$];
  int           send_gap_pct;
  int           fail_count;
  int           idle_cycles;

  first_fit_heap_allocator_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_request_bytes(in_request_bytes),
    .in_free_offset(in_free_offset), .out_valid(out_valid),
    .out_status(out_status), .out_payload_offset(out_payload_offset),
    .out_avail_bytes(out_avail_bytes)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Model of the heap table: reset to one free block spanning the heap
  task automatic heap_reset();
    for (int k = 0; k < NBLK; k++) begin
      blk_size[k] = 0;
      blk_busy[k] = 0;
    end
    blk_size[0] = HEAP + HDR;
    blk_count = 1;
    free_total = HEAP;
  endtask

  task automatic join_with_prev(int unsigned idx);
    blk_size[idx-1] += blk_size[idx];
    for (int unsigned j = idx; j + 1 < blk_count; j++) begin
      blk_size[j] = blk_size[j+1];
      blk_busy[j] = blk_busy[j+1];
    end
    blk_count--;
  endtask

  // Predict the result of one item and update the heap table
  task automatic predict_heap_op(logic act, logic [12:0] req, logic [15:0] where,
                                 output heap_result_t r);
    int unsigned sz, i, off, rem, sum;
    r = '0;
    off = 0;
    if (act == ffha_pkg::ACT_ALLOC) begin
      sz = ((req + ALIGN - 1) / ALIGN) * ALIGN;
      r.status = ffha_pkg::ST_REFUSED;
      if (sz != 0 && free_total >= sz) begin
        for (i = 0; i < blk_count; i++) begin
          if (!blk_busy[i] && blk_size[i] - HDR >= sz) break;
          off += blk_size[i];
        end
        if (i < blk_count) begin
          blk_busy[i] = 1;
          rem = blk_size[i] - HDR - sz;
          if (rem >= HDR && blk_count < NBLK) begin
            for (int unsigned j = blk_count; j > i + 1; j--) begin
              blk_size[j] = blk_size[j-1];
              blk_busy[j] = blk_busy[j-1];
            end
            blk_size[i] = HDR + sz;
            blk_size[i+1] = rem;
            blk_busy[i+1] = 0;
            blk_count++;
          end
          r.status = ffha_pkg::ST_OK;
          r.offset = off[11:0];
        end
      end
    end else begin
      r.status = ffha_pkg::ST_BADFREE;
      if (where % ALIGN == 0) begin
        for (i = 0; i < blk_count; i++) begin
          if (off == where) break;
          off += blk_size[i];
        end
        if (i < blk_count && blk_busy[i]) begin
          blk_busy[i] = 0;
          if (i + 1 < blk_count && !blk_busy[i+1]) join_with_prev(i + 1);
          if (i > 0 && !blk_busy[i-1]) join_with_prev(i);
          r.status = ffha_pkg::ST_OK;
        end
      end
    end
    sum = 0;
    for (int unsigned k = 0; k < blk_count; k++)
      if (!blk_busy[k]) sum += blk_size[k] - HDR;
    free_total = sum;
    r.avail = free_total[12:0];
  endtask

  // Send one item: optional idle gap, then hold start until accepted
  task automatic send_item(logic act, logic [12:0] req, logic [15:0] where);
    heap_result_t r;
    if ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    start            <= 1'b1;
    in_action        <= act;
    in_request_bytes <= req;
    in_free_offset   <= where;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_heap_op(act, req, where, r);
    expected_q.push_back(r);
    if (act == ffha_pkg::ACT_ALLOC && r.status == ffha_pkg::ST_OK)
      live_offsets.push_back(r.offset);
  endtask

  task automatic do_alloc(logic [12:0] req);
    send_item(ffha_pkg::ACT_ALLOC, req, 16'($urandom));
  endtask

  task automatic do_free(logic [15:0] where);
    for (int k = 0; k < live_offsets.size(); k++)
      if (live_offsets[k] == where) begin
        live_offsets.delete(k);
        break;
      end
    send_item(ffha_pkg::ACT_FREE, 13'($urandom), where);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result st=%0d off=%0d avail=%0d", $time,
                 out_status, out_payload_offset, out_avail_bytes);
        fail_count++;
      end else begin
        heap_result_t e;
        e = expected_q.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          fail_count++;
        end
        if (out_payload_offset !== e.offset) begin
          $display("%0t: offset exp %0d got %0d", $time, e.offset, out_payload_offset);
          fail_count++;
        end
        if (out_avail_bytes !== e.avail) begin
          $display("%0t: avail exp %0d got %0d", $time, e.avail, out_avail_bytes);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted item or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Extremes of fields and every special case
  task automatic test_directed();
    do_alloc(13'd0);
    do_alloc(13'd1);
    do_alloc(13'd4096);
    do_alloc(13'h1fff);
    do_alloc(13'd7);
    do_alloc(13'd9);
    do_free(16'd3);
    do_free(16'hffff);
    do_free(16'hfff8);
    do_free(16'd8);
    do_free(16'd0);
    do_free(16'd0);
    do_free(16'd40);
    do_free(16'd16);
    do_alloc(13'd4096);
    do_free(16'd0);
    do_alloc(13'd4080);
    do_alloc(13'd4096);
    do_free(16'd0);
    do_alloc(13'd4088);
    do_alloc(13'd8);
    do_free(16'd0);
  endtask

  // Fill the table past its capacity with tiny blocks
  task automatic test_table_full();
    for (int k = 0; k < 70; k++) do_alloc(13'd8);
    do_alloc(13'd16);
    while (live_offsets.size() != 0)
      do_free(16'(live_offsets[$urandom_range(live_offsets.size() - 1)]));
  endtask

  // Mixed random traffic: allocations, valid frees of live blocks and random frees
  task automatic test_random(int n);
    int unsigned sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        if ($urandom_range(9) == 0) do_alloc(13'($urandom));
        else if ($urandom_range(3) == 0) do_alloc(13'($urandom_range(4096)));
        else do_alloc(13'($urandom_range(200)));
      end else if (sel < 88 && live_offsets.size() != 0) begin
        do_free(16'(live_offsets[$urandom_range(live_offsets.size() - 1)]));
      end else if (sel < 94) begin
        do_free(16'($urandom));
      end else begin
        do_free(16'($urandom_range(511) * ALIGN));
      end
    end
  endtask

  initial begin
    fail_count = 0;
    idle_cycles = 0;
    send_gap_pct = 28;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = 1'b0;
    in_request_bytes = '0;
    in_free_offset = '0;
    heap_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(170);
    send_gap_pct = 52;
    test_random(170);
    send_gap_pct = 0;
    test_random(170);
    drain();
    repeat (4 * NBLK + 10) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/ffha_pkg.sv
rtl/first_fit_heap_allocator_top.sv
tb/tb_top.sv
